### src/dcenc_pkg.sv
// ----------------------------------------------------------------------------
// Dictionary encoder package
// Shared types, constants and the element-width cut used by the encoder.
// ----------------------------------------------------------------------------
package dcenc_pkg;

	// Default dictionary depth and the widest code the cells can carry.
	localparam int DICT_DEPTH_DEF = 1024;
	localparam int CODE_W         = 16;

	// Field widths of the result word.
	localparam int VALUE_W     = 64;
	localparam int CODE_OUT_W  = 10;
	localparam int ENTRY_W     = 11;
	localparam int CLASS_W     = 2;

	// Entry-count thresholds for the index width class.
	localparam int unsigned ONE_BYTE_LIMIT = 128;
	localparam int unsigned TWO_BYTE_LIMIT = 32768;

	// Element width selected by the configuration register.
	typedef enum logic [1:0] {
		ELEM_INT8  = 2'd0,
		ELEM_INT16 = 2'd1,
		ELEM_INT32 = 2'd2,
		ELEM_INT64 = 2'd3
	} elem_type_t;

	// Index width class reported with each result.
	typedef enum logic [CLASS_W-1:0] {
		CLASS_ONE_BYTE  = 2'd0,
		CLASS_TWO_BYTES = 2'd1,
		CLASS_FOUR_BYTES = 2'd2
	} index_class_t;

	// Token that travels down the cell chain, one cell per cycle.
	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               hit;
		logic               is_new;
		logic [CODE_W-1:0]  code;
	} dcenc_tok_t;

	// Keep the low bits of the selected width and sign-extend them.
	function automatic logic [VALUE_W-1:0] cut_to_width(
		input logic [VALUE_W-1:0] x,
		input elem_type_t         et
	);
		logic [VALUE_W-1:0] r;
		unique case (et)
			ELEM_INT8:  r = {{(VALUE_W-8){x[7]}}, x[7:0]};
			ELEM_INT16: r = {{(VALUE_W-16){x[15]}}, x[15:0]};
			ELEM_INT32: r = {{(VALUE_W-32){x[31]}}, x[31:0]};
			default:    r = x;
		endcase
		return r;
	endfunction

endpackage

### src/dcenc_cell.sv
// ----------------------------------------------------------------------------
// Dictionary encoder cell
// Holds one dictionary entry, checks the passing word against it, claims the
// word when the slot is free, and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module dcenc_cell #(
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dcenc_pkg::dcenc_tok_t tok_in,
	output dcenc_pkg::dcenc_tok_t tok_out
);
	import dcenc_pkg::*;

	logic               used_q;
	logic [VALUE_W-1:0] entry_q;
	logic               match;
	logic               claim;
	dcenc_tok_t         tok_nxt;
	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;
	logic               hit_q;
	logic               is_new_q;
	logic [CODE_W-1:0]  code_q;

	// A word that has not yet found a home either matches this entry or,
	// if the slot is free, becomes this entry. Entries fill in order, so a
	// free slot means no later cell holds the value.
	always_comb begin
		match   = tok_in.valid && !tok_in.hit && used_q && (tok_in.value == entry_q);
		claim   = tok_in.valid && !tok_in.hit && !used_q;
		tok_nxt = tok_in;
		if (match || claim) begin
			tok_nxt.hit    = 1'b1;
			tok_nxt.is_new = claim;
			tok_nxt.code   = CODE_W'(INDEX);
		end
	end

	// Slot occupancy; the last word of a column frees the slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (tok_in.valid && tok_in.last) begin
			used_q <= 1'b0;
		end else if (claim) begin
			used_q <= 1'b1;
		end
	end

	// Stored value, written only when the slot is claimed.
	always_ff @(posedge clk) begin
		if (claim) begin
			entry_q <= tok_in.value;
		end
	end

	// Hand-off register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q  <= tok_nxt.value;
		last_q   <= tok_nxt.last;
		hit_q    <= tok_nxt.hit;
		is_new_q <= tok_nxt.is_new;
		code_q   <= tok_nxt.code;
	end

	always_comb begin
		tok_out.valid  = valid_q;
		tok_out.value  = value_q;
		tok_out.last   = last_q;
		tok_out.hit    = hit_q;
		tok_out.is_new = is_new_q;
		tok_out.code   = code_q;
	end

endmodule

### src/dictionary_encoder_top.sv
// ----------------------------------------------------------------------------
// Dictionary encoder top level
// Each word passes from start to done through every cell register of the chain
// and then the result register. Throughput: one word per cycle; busy
// stays low. The receiver cannot stall; each result shows for one cycle.
// Reset empties the dictionary, zeroes the entry count, sets type int64.
// ----------------------------------------------------------------------------
module dictionary_encoder_top #(
	parameter int DICT_DEPTH = dcenc_pkg::DICT_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [dcenc_pkg::VALUE_W-1:0] value,
	input  logic                               last,
	output logic                               done,
	output logic [dcenc_pkg::CODE_OUT_W-1:0]   code,
	output logic                               is_new,
	output logic                               overflow,
	output logic [dcenc_pkg::ENTRY_W-1:0]      entry_count,
	output logic [dcenc_pkg::CLASS_W-1:0]      index_bytes,
	output logic                               end_of_column
);
	import dcenc_pkg::*;

	localparam int CNT_W = $clog2(DICT_DEPTH + 1);

	elem_type_t          elem_type_q;
	dcenc_tok_t          head;
	dcenc_tok_t          tok [DICT_DEPTH+1];
	dcenc_tok_t          tail;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_new;
	index_class_t        class_new;
	logic                done_q;
	logic [CODE_OUT_W-1:0] code_q;
	logic                is_new_q;
	logic                overflow_q;
	logic [ENTRY_W-1:0]  entry_count_q;
	index_class_t        class_q;
	logic                eoc_q;

	// The chain accepts a word every cycle.
	assign busy = 1'b0;

	// Element type register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_type_q <= ELEM_INT64;
		end else if (cfg_we) begin
			elem_type_q <= elem_type_t'(cfg_wdata);
		end
	end

	// Word entering the chain, cut to the configured element width.
	always_comb begin
		head.valid  = start;
		head.value  = cut_to_width(value, elem_type_q);
		head.last   = last;
		head.hit    = 1'b0;
		head.is_new = 1'b0;
		head.code   = '0;
	end

	assign tok[0] = head;

	// Row of entry cells.
	for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
		dcenc_cell #(
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign tail = tok[DICT_DEPTH];

	// Running entry count and width class as the word leaves the chain.
	always_comb begin
		cnt_new = cnt_q + CNT_W'(tail.is_new);
		if (32'(cnt_new) < ONE_BYTE_LIMIT) begin
			class_new = CLASS_ONE_BYTE;
		end else if (32'(cnt_new) < TWO_BYTE_LIMIT) begin
			class_new = CLASS_TWO_BYTES;
		end else begin
			class_new = CLASS_FOUR_BYTES;
		end
	end

	// Entry count; it returns to zero after the last word of a column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (tail.valid) begin
			cnt_q <= tail.last ? '0 : cnt_new;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	// Result word; a word that found neither a match nor a free slot overflows.
	always_ff @(posedge clk) begin
		code_q        <= tail.hit ? CODE_OUT_W'(tail.code) : '0;
		is_new_q      <= tail.is_new;
		overflow_q    <= !tail.hit;
		entry_count_q <= ENTRY_W'(cnt_new);
		class_q       <= class_new;
		eoc_q         <= tail.last;
	end

	assign done          = done_q;
	assign code          = code_q;
	assign is_new        = is_new_q;
	assign overflow      = overflow_q;
	assign entry_count   = entry_count_q;
	assign index_bytes   = class_q;
	assign end_of_column = eoc_q;

endmodule
